// File: src/adsr_pkg.sv
// adsr_pkg: widths, reset values, op codes, register indexes and the divider request
// type shared by the envelope generator top level and its serial divider
// no dependencies
package adsr_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int IN_TIME_W     = 32;
    localparam int TICK_W        = 24;
    localparam int LEVEL_W       = 16;
    localparam int PROD_W        = TICK_W + LEVEL_W;
    localparam int QUO_W         = LEVEL_W;
    localparam int CNT_W         = $clog2(QUO_W);
    localparam int OP_W          = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = TICK_W;

    typedef logic [OP_W-1:0]      op_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_SAMPLE   = 2'd0;
    localparam op_t OP_NOTE_ON  = 2'd1;
    localparam op_t OP_NOTE_OFF = 2'd2;

    localparam cfg_idx_t REG_ATTACK  = 3'd0;
    localparam cfg_idx_t REG_DECAY   = 3'd1;
    localparam cfg_idx_t REG_SUSTAIN = 3'd2;
    localparam cfg_idx_t REG_RELEASE = 3'd3;
    localparam cfg_idx_t REG_START   = 3'd4;

    localparam logic [TICK_W-1:0]  ATTACK_RST  = 24'd0;
    localparam logic [TICK_W-1:0]  DECAY_RST   = 24'd4410;
    localparam logic [LEVEL_W-1:0] SUSTAIN_RST = 16'd32768;
    localparam logic [TICK_W-1:0]  RELEASE_RST = 24'd4410;
    localparam logic [LEVEL_W-1:0] START_RST   = 16'd32768;

    // levels at or below this read as silence
    localparam logic [LEVEL_W-1:0] FLOOR_LEVEL = 16'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'hFFFF;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [TICK_W-1:0]   divisor;
    } div_req_t;

endpackage

// File: src/adsr_div.sv
// adsr_div: restoring serial divider, one quotient bit per cycle, one shared
// subtract and compare; assumes the quotient fits in QUO_W bits
// depends on adsr_pkg
module adsr_div
    import adsr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [TICK_W-1:0] rem_reg;
    logic [QUO_W-1:0]  num_reg;
    logic [TICK_W-1:0] div_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [TICK_W:0]   trial;
    logic [TICK_W:0]   trial_sub;
    logic              fits;

    assign trial     = {rem_reg, num_reg[QUO_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign fits      = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // payload: remainder, dividend bits shifting out, quotient bits shifting in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[PROD_W-1:QUO_W];
            num_reg <= req.dividend[QUO_W-1:0];
            div_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub[TICK_W-1:0] : trial[TICK_W-1:0];
            num_reg <= {num_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// File: src/adsr_envelope_generator_top.sv
// adsr_envelope_generator_top: linear attack, decay, sustain, release envelope
// with a shared multiplier and serial divider under a small sequencer
// depends on adsr_pkg and adsr_div
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | in_valid, in_ready, op, time_ticks   | in
//   output   | out_valid, out_ready, amplitude      | out
//   config   | cfg_wr_en, cfg_index, cfg_data       | in
//
// a ramp item passes from its input transaction through the diff, select, multiply,
// divider start, divide and finish states, the serial divider giving one quotient
// bit per cycle (QUO_W = 16); a sustain or silent item goes from select to finish
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register and the sequencer holds it until out_ready frees that
// register; reset restores the register defaults and clears gate and note times
module adsr_envelope_generator_top
    import adsr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       op,
    input  logic [IN_TIME_W-1:0]  time_ticks,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEVEL_W-1:0]    amplitude,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CMP_W = (TIME_BITS > TICK_W + 1) ? TIME_BITS : TICK_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SEL,
        S_MUL,
        S_START,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg;

    logic [TICK_W-1:0]  attack_reg;
    logic [TICK_W-1:0]  decay_reg;
    logic [LEVEL_W-1:0] sustain_reg;
    logic [TICK_W-1:0]  release_reg;
    logic [LEVEL_W-1:0] start_reg;

    logic                 gate_reg;
    logic [TIME_BITS-1:0] on_time_reg;
    logic [TIME_BITS-1:0] off_time_reg;
    logic [TIME_BITS-1:0] t_reg;
    logic [TIME_BITS-1:0] diff_reg;

    logic [TICK_W-1:0]  mul_a_reg;
    logic [LEVEL_W-1:0] mul_b_reg;
    logic [TICK_W-1:0]  divisor_reg;
    logic [LEVEL_W-1:0] base_reg;
    logic               sub_reg;
    logic               bypass_reg;
    logic [LEVEL_W-1:0] value_reg;
    logic [PROD_W-1:0]  prod_reg;

    logic               out_valid_reg;
    logic [LEVEL_W-1:0] amplitude_reg;

    logic [TIME_BITS+IN_TIME_W-1:0] t_wide;
    logic [TIME_BITS-1:0]           t_in;
    logic [CMP_W-1:0]               diff_ext;
    logic [TICK_W:0]                ad_sum;
    logic [TICK_W-1:0]              decay_pos;
    logic                           in_attack;
    logic                           in_decay;
    logic                           rel_done;

    logic               sel_bypass;
    logic [LEVEL_W-1:0] sel_value;
    logic [TICK_W-1:0]  sel_mul_a;
    logic [LEVEL_W-1:0] sel_mul_b;
    logic [TICK_W-1:0]  sel_div;
    logic [LEVEL_W-1:0] sel_base;
    logic               sel_sub;

    div_req_t           div_req;
    logic               div_done;
    logic [QUO_W-1:0]   div_quo;

    logic [LEVEL_W:0]   raw_sum;
    logic [LEVEL_W:0]   raw;
    logic [LEVEL_W-1:0] result;

    // time is taken modulo 2^TIME_BITS
    assign t_wide = {{TIME_BITS{1'b0}}, time_ticks};
    assign t_in   = t_wide[TIME_BITS-1:0];

    assign diff_ext  = CMP_W'(diff_reg);
    assign ad_sum    = {1'b0, attack_reg} + {1'b0, decay_reg};
    assign decay_pos = diff_ext[TICK_W-1:0] - attack_reg;
    assign in_attack = (attack_reg != '0) && (diff_ext <= CMP_W'(attack_reg));
    assign in_decay  = (decay_reg != '0) && (diff_ext <= CMP_W'(ad_sum));
    assign rel_done  = diff_ext >= CMP_W'(release_reg);

    // phase select
    always_comb
    begin
        sel_bypass = 1'b0;
        sel_value  = '0;
        sel_mul_a  = diff_ext[TICK_W-1:0];
        sel_mul_b  = sustain_reg;
        sel_div    = release_reg;
        sel_base   = sustain_reg;
        sel_sub    = 1'b1;
        if (gate_reg)
        begin
            if (in_attack)
            begin
                sel_mul_b = start_reg;
                sel_div   = attack_reg;
                sel_base  = '0;
                sel_sub   = 1'b0;
            end
            else if (in_decay)
            begin
                sel_mul_a = decay_pos;
                sel_div   = decay_reg;
                sel_base  = start_reg;
                if (sustain_reg >= start_reg)
                begin
                    sel_mul_b = sustain_reg - start_reg;
                    sel_sub   = 1'b0;
                end
                else
                begin
                    sel_mul_b = start_reg - sustain_reg;
                    sel_sub   = 1'b1;
                end
            end
            else
            begin
                sel_bypass = 1'b1;
                sel_value  = sustain_reg;
            end
        end
        else if (rel_done)
        begin
            sel_bypass = 1'b1;
            sel_value  = '0;
        end
    end

    assign div_req.start    = (state_reg == S_START);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = divisor_reg;

    adsr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    // result with silence floor and saturation
    assign raw_sum = sub_reg ? ({1'b0, base_reg} - {1'b0, div_quo})
                             : ({1'b0, base_reg} + {1'b0, div_quo});
    assign raw     = bypass_reg ? {1'b0, value_reg} : raw_sum;

    always_comb
    begin
        if (raw > {1'b0, LEVEL_MAX})
        begin
            result = LEVEL_MAX;
        end
        else if (raw <= {1'b0, FLOOR_LEVEL})
        begin
            result = '0;
        end
        else
        begin
            result = raw[LEVEL_W-1:0];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= ATTACK_RST;
            decay_reg   <= DECAY_RST;
            sustain_reg <= SUSTAIN_RST;
            release_reg <= RELEASE_RST;
            start_reg   <= START_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ATTACK:  attack_reg  <= cfg_data;
                REG_DECAY:   decay_reg   <= cfg_data;
                REG_SUSTAIN: sustain_reg <= cfg_data[LEVEL_W-1:0];
                REG_RELEASE: release_reg <= cfg_data;
                REG_START:   start_reg   <= cfg_data[LEVEL_W-1:0];
                default:     ;
            endcase
        end
    end

    // sequencer, note state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gate_reg      <= 1'b0;
            on_time_reg   <= '0;
            off_time_reg  <= '0;
            out_valid_reg <= 1'b0;
            amplitude_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (op == OP_NOTE_ON)
                        begin
                            on_time_reg <= t_in;
                            gate_reg    <= 1'b1;
                        end
                        else if (op == OP_NOTE_OFF)
                        begin
                            off_time_reg <= t_in;
                            gate_reg     <= 1'b0;
                        end
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF:  state_reg <= S_SEL;
                S_SEL:   state_reg <= sel_bypass ? S_FIN : S_MUL;
                S_MUL:   state_reg <= S_START;
                S_START: state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        amplitude_reg <= result;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            t_reg <= t_in;
        end
        if (state_reg == S_DIFF)
        begin
            diff_reg <= t_reg - (gate_reg ? on_time_reg : off_time_reg);
        end
        if (state_reg == S_SEL)
        begin
            mul_a_reg   <= sel_mul_a;
            mul_b_reg   <= sel_mul_b;
            divisor_reg <= sel_div;
            base_reg    <= sel_base;
            sub_reg     <= sel_sub;
            bypass_reg  <= sel_bypass;
            value_reg   <= sel_value;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= PROD_W'(mul_a_reg) * PROD_W'(mul_b_reg);
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign amplitude = amplitude_reg;

endmodule

// File: src/adsr_checker.sv
// adsr_port_checker: port-level checks on the envelope generator, attached by bind
// depends on adsr_pkg and adsr_envelope_generator_top
module adsr_port_checker
    import adsr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [LEVEL_W-1:0] amplitude
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(amplitude))
        else $error("output changed while stalled");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // no result appears in the cycle after an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");

    // levels at the floor read as silence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> amplitude == '0 || amplitude > FLOOR_LEVEL)
        else $error("amplitude below floor not zeroed");

endmodule

bind adsr_envelope_generator_top adsr_port_checker u_adsr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .amplitude (amplitude)
);

// File: tb/adsr_checker.sv
`timescale 1ns / 100ps
// adsr_checker: watches the envelope generator's channels and register port, predicts
// each amplitude from its own copy of the registers and note state, and compares
// depends on adsr_pkg
module adsr_checker
    import adsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  op_t                   op,
    input  logic [IN_TIME_W-1:0]  time_ticks,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [LEVEL_W-1:0]    amplitude,
    input  logic                  cfg_wr_en,
    input  cfg_idx_t              cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    compared
);

    logic [TICK_W-1:0]    attack_len;
    logic [TICK_W-1:0]    decay_len;
    logic [TICK_W-1:0]    release_len;
    logic [LEVEL_W-1:0]   sustain_lvl;
    logic [LEVEL_W-1:0]   peak_lvl;
    logic                 note_held;
    logic [IN_TIME_W-1:0] note_on_at;
    logic [IN_TIME_W-1:0] note_off_at;
    logic [LEVEL_W-1:0]   amp_due[$];
    logic [LEVEL_W-1:0]   want_amp;
    int                   fail_tally;
    int                   match_tally;

    task automatic report_mismatch(input string msg);
        fail_tally++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic logic [LEVEL_W-1:0] envelope_level(input logic [IN_TIME_W-1:0] t);
        logic [IN_TIME_W-1:0] diff;
        logic [63:0]          span;
        logic [63:0]          a;
        logic [63:0]          d;
        logic [63:0]          r;
        logic [63:0]          st;
        logic [63:0]          su;
        logic [63:0]          lvl;
        a  = attack_len;
        d  = decay_len;
        r  = release_len;
        st = peak_lvl;
        su = sustain_lvl;
        if (note_held) begin
            diff = t - note_on_at;
            span = diff;
            if (a != 0 && span <= a)
                lvl = (span * st) / a;
            else if (d != 0 && span <= a + d) begin
                if (su >= st)
                    lvl = st + ((span - a) * (su - st)) / d;
                else
                    lvl = st - ((span - a) * (st - su)) / d;
            end
            else
                lvl = su;
        end
        else begin
            diff = t - note_off_at;
            span = diff;
            if (span >= r)
                lvl = 0;
            else
                lvl = su - (span * su) / r;
        end
        if (lvl <= FLOOR_LEVEL)
            lvl = 0;
        if (lvl > LEVEL_MAX)
            lvl = LEVEL_MAX;
        return lvl[LEVEL_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len  = ATTACK_RST;
            decay_len   = DECAY_RST;
            release_len = RELEASE_RST;
            sustain_lvl = SUSTAIN_RST;
            peak_lvl    = START_RST;
            note_held   = 1'b0;
            note_on_at  = '0;
            note_off_at = '0;
            amp_due.delete();
            fail_tally  = 0;
            match_tally = 0;
            mismatches  <= 0;
            pending     <= 0;
            compared    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ATTACK:  attack_len  = cfg_data;
                    REG_DECAY:   decay_len   = cfg_data;
                    REG_SUSTAIN: sustain_lvl = cfg_data[LEVEL_W-1:0];
                    REG_RELEASE: release_len = cfg_data;
                    REG_START:   peak_lvl    = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (op == OP_NOTE_ON)
                begin
                    note_on_at = time_ticks;
                    note_held  = 1'b1;
                end
                else if (op == OP_NOTE_OFF)
                begin
                    note_off_at = time_ticks;
                    note_held   = 1'b0;
                end
                amp_due.push_back(envelope_level(time_ticks));
            end
            if (out_valid && out_ready)
            begin
                if (amp_due.size() == 0)
                    report_mismatch($sformatf("amplitude %0d with none outstanding", amplitude));
                else
                begin
                    want_amp = amp_due.pop_front();
                    match_tally++;
                    if (amplitude !== want_amp)
                        report_mismatch($sformatf("amplitude got %0d, wanted %0d",
                                                  amplitude, want_amp));
                end
            end
            mismatches <= fail_tally;
            compared   <= match_tally;
            pending    <= amp_due.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: drives note and sample transactions and register settings into the envelope
// generator under mixed idling, with adsr_checker alongside; gives the verdict
// depends on adsr_pkg, adsr_envelope_generator_top and adsr_checker
module tb;
    import adsr_pkg::*;

    localparam op_t OP_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    op_t                   op = OP_SAMPLE;
    logic [IN_TIME_W-1:0]  time_ticks = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [LEVEL_W-1:0]    amplitude;
    logic                  cfg_wr_en = 1'b0;
    cfg_idx_t              cfg_index = REG_ATTACK;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;
    int compared;

    int                   sender_idle_pct = 0;
    int                   stall_pct = 0;
    int                   hold_trigger = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    int                   sent_count = 0;
    int                   setting_count = 0;
    int unsigned          time_scale = 1766;
    logic [IN_TIME_W-1:0] now_t = '0;
    int                   sender_tab[4] = '{0, 65, 0, 25};
    int                   stall_tab[4]  = '{0, 0, 65, 25};

    adsr_envelope_generator_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .time_ticks (time_ticks),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .amplitude  (amplitude),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    adsr_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .time_ticks (time_ticks),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .amplitude  (amplitude),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .compared   (compared)
    );

    always #2 clk = ~clk;

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_trigger)
        begin
            hold_seen <= hold_trigger;
            hold_left <= 300;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_item(input op_t o, input logic [IN_TIME_W-1:0] t);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        time_ticks <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic apply_setting(input logic [TICK_W-1:0] a, input logic [TICK_W-1:0] d,
                                 input logic [LEVEL_W-1:0] su, input logic [TICK_W-1:0] r,
                                 input logic [LEVEL_W-1:0] st);
        drain();
        repeat (30) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ATTACK;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= REG_DECAY;
        cfg_data  <= d;
        @(posedge clk);
        cfg_index <= REG_SUSTAIN;
        cfg_data  <= CFG_DATA_W'(su);
        @(posedge clk);
        cfg_index <= REG_RELEASE;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= REG_START;
        cfg_data  <= CFG_DATA_W'(st);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        time_scale = int'((64'(a) + 64'(d) + 64'(r)) / 5) + 2;
        setting_count++;
    endtask

    function automatic logic [TICK_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return TICK_W'($urandom);
            default: return TICK_W'($urandom_range(1, 400));
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return LEVEL_MAX;
            2: return LEVEL_W'($urandom_range(0, 8));
            default: return LEVEL_W'($urandom);
        endcase
    endfunction

    task automatic step_time();
        now_t = now_t + IN_TIME_W'($urandom_range(0, time_scale));
    endtask

    task automatic run_random(input int n);
        int goal;
        int k;
        int pick;
        goal = sent_count + n;
        while (sent_count < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                step_time();
                send_item(OP_NOTE_ON, now_t);
                k = $urandom_range(1, 8);
                repeat (k)
                begin
                    step_time();
                    send_item(OP_SAMPLE, now_t);
                end
                step_time();
                send_item(OP_NOTE_OFF, now_t);
                k = $urandom_range(1, 6);
                repeat (k)
                begin
                    step_time();
                    send_item(OP_SAMPLE, now_t);
                end
            end
            else if (pick == 8)
            begin
                if ($urandom_range(0, 1) == 1)
                    now_t = $urandom;
                else
                    now_t = now_t - IN_TIME_W'($urandom_range(0, time_scale));
                send_item(op_t'($urandom_range(0, 3)), now_t);
            end
            else
                send_item(op_t'($urandom_range(0, 3)), now_t);
        end
    endtask

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: release from time zero, zero attack, then decay and release
        send_item(OP_SAMPLE, 32'd0);
        send_item(OP_SAMPLE, 32'd2205);
        send_item(OP_SAMPLE, 32'd4410);
        send_item(OP_UNUSED, 32'd4500);
        send_item(OP_NOTE_ON, 32'd5000);
        send_item(OP_SAMPLE, 32'd7205);
        send_item(OP_SAMPLE, 32'd9410);
        send_item(OP_NOTE_OFF, 32'd10000);
        send_item(OP_SAMPLE, 32'd11000);

        // zero decay and zero release at full levels
        apply_setting(24'd100, '0, LEVEL_MAX, '0, LEVEL_MAX);
        send_item(OP_NOTE_ON, 32'd20000);
        send_item(OP_SAMPLE, 32'd20050);
        send_item(OP_SAMPLE, 32'd20100);
        send_item(OP_SAMPLE, 32'd20101);
        send_item(OP_NOTE_OFF, 32'd20200);

        // longest phases, time wrapping and running backwards
        apply_setting('1, '1, '0, '1, LEVEL_MAX);
        send_item(OP_NOTE_ON, 32'hFFFF_FF00);
        send_item(OP_SAMPLE, 32'hFFFF_FFFF);
        send_item(OP_SAMPLE, 32'h00FF_0000);
        send_item(OP_SAMPLE, 32'h0200_0000);
        send_item(OP_SAMPLE, 32'h0100_0000);
        send_item(OP_NOTE_OFF, 32'h1000_0000);
        send_item(OP_SAMPLE, 32'h0FFF_FFFF);
        now_t = 32'h1000_0000;

        for (int m = 0; m < 4; m++)
        begin
            sender_idle_pct = sender_tab[m];
            stall_pct <= stall_tab[m];
            for (int s = 0; s < 2; s++)
            begin
                apply_setting(pick_len(), pick_len(), pick_level(), pick_len(), pick_level());
                if (m == 0 && s == 0)
                    hold_trigger <= hold_trigger + 1;
                if (m == 1 && s == 0)
                begin
                    run_random(31);
                    drain();
                    run_random(31);
                end
                else
                    run_random(62);
            end
        end

        drain();
        repeat (40) @(posedge clk);
        $display("%0d transactions over %0d register settings and four idling mixes",
                 sent_count, setting_count);
        $display("%0d amplitudes compared, %0d mismatches", compared, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
